FILE: sv/sm3_hash_engine_defines.svh
// assertion helpers for the sm3 hash engine
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

// same-cycle implication
`define SM3_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sm3 check failed");

// next-cycle implication
`define SM3_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sm3 check failed");

`endif

FILE: sv/sm3_pkg.sv
`default_nettype none
package sm3_pkg;

    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };
    localparam logic [31:0] SM3_T0 = 32'h79cc4519;
    // second round constant already rotated left by 16 (its first use is round 16)
    localparam logic [31:0] SM3_T1_R16 = 32'h9d8a7a87;
    localparam logic [7:0] SM3_PAD_BYTE = 8'h80;
    localparam logic [5:0] SM3_LEN_POS = 6'd56;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FEED = 6'b000010,
        ST_PAD  = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_COMP = 6'b010000,
        ST_OUT  = 6'b100000
    } sm3_state_t;

    typedef struct packed {
        logic start;
        logic init;
    } sm3_ctl_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage
`default_nettype wire

FILE: sv/sm3_core.sv
`default_nettype none
module sm3_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sm3_pkg::sm3_ctl_t ctl,
    input  wire logic [511:0]     blk,
    output logic      [255:0]     cv,
    output logic                  done
);
    import sm3_pkg::*;

    logic [255:0] cv_reg, cv_next;
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    logic [31:0]  t_reg, t_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    logic         early;

    // one round of compression and message expansion
    always_comb
    begin
        early = (rnd_reg[5:4] == 2'b00);
        a12 = rotl(a_reg, 12);
        ss1 = rotl(a12 + e_reg + t_reg, 7);
        ss2 = ss1 ^ a12;
        ff  = early ? (a_reg ^ b_reg ^ c_reg)
                    : ((a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg));
        gg  = early ? (e_reg ^ f_reg ^ g_reg) : ((e_reg & f_reg) | (~e_reg & g_reg));
        tt1 = ff + d_reg + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + h_reg + ss1 + w_reg[0];
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 15))
                ^ rotl(w_reg[3], 7) ^ w_reg[10];
    end

    // sequencer
    always_comb
    begin
        cv_next = cv_reg;
        w_next = w_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; f_next = f_reg; g_next = g_reg; h_next = h_reg;
        t_next = t_reg;
        rnd_next = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.init)
        begin
            cv_next = SM3_IV;
        end
        else if (ctl.start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = blk[511 - 32 * i -: 32];
            end
            {a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next} = cv_reg;
            t_next = SM3_T0;
            rnd_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
            d_next = c_reg; c_next = rotl(b_reg, 9); b_next = a_reg; a_next = tt1;
            h_next = g_reg; g_next = rotl(f_reg, 19); f_next = e_reg; e_next = perm0(tt2);
            t_next = (rnd_reg == 6'd15) ? SM3_T1_R16 : rotl(t_reg, 1);
            rnd_next = rnd_reg + 6'd1;
            if (&rnd_reg)
            begin
                cv_next = cv_reg ^ {tt1, a_reg, rotl(b_reg, 9), c_reg,
                                    perm0(tt2), e_reg, rotl(f_reg, 19), g_reg};
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= SM3_IV;
            rnd_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cv_reg <= cv_next;
            rnd_reg <= rnd_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        e_reg <= e_next; f_reg <= f_next; g_reg <= g_next; h_reg <= h_next;
        t_reg <= t_next;
    end

    assign cv = cv_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

FILE: sv/sm3_hash_engine.sv
// SM3 hash engine: message words of up to 8 bytes go in on the input channel, and after the word
// flagged final the 256-bit digest comes out as four 64-bit parts, the last one marked. An
// accepted word's valid bytes shift into the block register one at a time, and each full 64-byte
// block then goes through a load step, the rounds of the single round unit and the hand-back of
// the chaining value. Padding after the final word shifts in one byte a cycle, except while a
// full block is compressed (up to 72 bytes, with one or two compressions), and each digest part
// waits for the output handshake.
// The input is not ready from acceptance until the item's work, and any digest, is done.
`default_nettype none
`include "sm3_hash_engine_defines.svh"
module sm3_hash_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        final_req,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [63:0] digest_part,
    output logic             digest_last
);
    import sm3_pkg::*;

    sm3_state_t   state_reg, state_next, after_reg, after_next, target;
    logic [511:0] blk_reg, blk_next;
    logic [63:0]  data_reg, data_next;
    logic [63:0]  len_reg, len_next;
    logic [60:0]  total_reg, total_next;
    logic [5:0]   fill_reg, fill_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [3:0]   n_clamp;
    logic [1:0]   part_reg, part_next;
    logic         fin_reg, fin_next;
    logic         first_reg, first_next;
    logic         lmode_reg, lmode_next;
    logic         len_now;
    logic [7:0]   push_byte;
    sm3_ctl_t     ctl;
    logic [255:0] cv;
    logic         core_done;

    sm3_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .blk   (blk_reg),
        .cv    (cv),
        .done  (core_done)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign digest_last = (part_reg == 2'd3);

    // digest part select
    always_comb
    begin
        case (part_reg)
            2'd0: digest_part = cv[255:192];
            2'd1: digest_part = cv[191:128];
            2'd2: digest_part = cv[127:64];
            default: digest_part = cv[63:0];
        endcase
    end

    // byte source for data and padding
    always_comb
    begin
        n_clamp = (byte_count > 4'd8) ? 4'd8 : byte_count;
        len_now = !first_reg && (lmode_reg || (fill_reg == SM3_LEN_POS));
        if (state_reg == ST_FEED)
        begin
            push_byte = data_reg[63:56];
            target = (cnt_reg == 4'd1) ? (fin_reg ? ST_PAD : ST_IDLE) : ST_FEED;
        end
        else
        begin
            push_byte = first_reg ? SM3_PAD_BYTE : (len_now ? len_reg[63:56] : 8'h00);
            target = (len_now && (&fill_reg)) ? ST_OUT : ST_PAD;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        blk_next = blk_reg;
        data_next = data_reg;
        len_next = len_reg;
        total_next = total_reg;
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        part_next = part_reg;
        fin_next = fin_reg;
        first_next = first_reg;
        lmode_next = lmode_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = data_word;
                    cnt_next = n_clamp;
                    fin_next = final_req;
                    total_next = total_reg + 61'(n_clamp);
                    len_next = {total_next, 3'b000};
                    first_next = 1'b1;
                    lmode_next = 1'b0;
                    state_next = (n_clamp != 4'd0) ? ST_FEED
                               : (final_req ? ST_PAD : ST_IDLE);
                end
            end
            ST_FEED, ST_PAD:
            begin
                blk_next = {blk_reg[503:0], push_byte};
                fill_next = fill_reg + 6'd1;
                if (state_reg == ST_FEED)
                begin
                    data_next = {data_reg[55:0], 8'h00};
                    cnt_next = cnt_reg - 4'd1;
                end
                else
                begin
                    first_next = 1'b0;
                    lmode_next = len_now;
                    if (len_now)
                    begin
                        len_next = {len_reg[55:0], 8'h00};
                    end
                end
                if (&fill_reg)
                begin
                    state_next = ST_LOAD;
                    after_next = target;
                end
                else
                begin
                    state_next = target;
                end
            end
            ST_LOAD:
            begin
                ctl.start = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (core_done)
                begin
                    state_next = after_reg;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        ctl.init = 1'b1;
                        total_next = '0;
                        fill_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
            total_reg <= '0;
            fill_reg <= '0;
            cnt_reg <= '0;
            part_reg <= '0;
            fin_reg <= 1'b0;
            first_reg <= 1'b0;
            lmode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            total_reg <= total_next;
            fill_reg <= fill_next;
            cnt_reg <= cnt_next;
            part_reg <= part_next;
            fin_reg <= fin_next;
            first_reg <= first_next;
            lmode_reg <= lmode_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        data_reg <= data_next;
        len_reg <= len_next;
    end

    // checks
    `SM3_ASSERT_NOW(a_ready_excl, in_ready, !out_valid)
    `SM3_ASSERT_NOW(a_start_aligned, ctl.start, fill_reg == 6'd0)
    `SM3_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && digest_last, in_ready)
    `SM3_ASSERT_NOW(a_len_pos, lmode_reg && (state_reg == ST_PAD), fill_reg >= SM3_LEN_POS)

endmodule
`default_nettype wire

FILE: dv/sm3_digest_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module sm3_digest_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        final_req,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [63:0] digest_part,
    input  wire logic        digest_last,
    output int               fail_count,
    output int               pending_parts,
    output int               digests_seen
);
    import sm3_pkg::*;

    typedef struct packed {
        logic [63:0] part;
        logic        last;
    } digest_item_t;

    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    int unsigned  block_fill;
    logic [60:0]  msg_bytes;
    digest_item_t digest_queue [$];

    function automatic logic [31:0] rot(input logic [31:0] x, input int n);
        int k;
        k = n % 32;
        if (k == 0)
            return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] p0f(input logic [31:0] x);
        return x ^ rot(x, 9) ^ rot(x, 17);
    endfunction

    function automatic logic [31:0] p1f(input logic [31:0] x);
        return x ^ rot(x, 15) ^ rot(x, 23);
    endfunction

    // one 64-round compression of the current block into the hash state
    task automatic compress();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++)
            w[j] = msg_block[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1f(w[j-16] ^ w[j-9] ^ rot(w[j-3], 15)) ^ rot(w[j-13], 7) ^ w[j-6];
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int j = 0; j < 64; j++)
        begin
            tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
            a12 = rot(a, 12);
            ss1 = rot(a12 + e + rot(tj, j), 7);
            ss2 = ss1 ^ a12;
            ff = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
            gg = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rot(b, 9); b = a; a = tt1;
            h = g; g = rot(f, 19); f = e; e = p0f(tt2);
        end
        hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
        hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
    endtask

    task automatic push_byte(input logic [7:0] v);
        msg_block[block_fill / 4][31 - 8 * (block_fill % 4) -: 8] = v;
        block_fill++;
        if (block_fill == 64)
        begin
            compress();
            block_fill = 0;
        end
    endtask

    task automatic restart();
        for (int i = 0; i < 8; i++)
            hash_state[i] = SM3_IV[255 - 32 * i -: 32];
        block_fill = 0;
        msg_bytes = '0;
    endtask

    // absorb one accepted word, emit the digest on the final one
    task automatic absorb_word(input logic [63:0] dw, input logic [3:0] cnt, input logic fin);
        int unsigned n;
        logic [63:0] bits;
        digest_item_t it;
        n = (cnt > 8) ? 8 : cnt;
        for (int i = 0; i < n; i++)
            push_byte(dw[63 - 8 * i -: 8]);
        msg_bytes = msg_bytes + 61'(n);
        if (fin)
        begin
            bits = {msg_bytes, 3'b000};
            push_byte(SM3_PAD_BYTE);
            if (block_fill > 56)
                while (block_fill != 0)
                    push_byte(8'h00);
            while (block_fill < 56)
                push_byte(8'h00);
            msg_block[14] = bits[63:32];
            msg_block[15] = bits[31:0];
            compress();
            for (int k = 0; k < 4; k++)
            begin
                it.part = {hash_state[2*k], hash_state[2*k+1]};
                it.last = (k == 3);
                digest_queue = {digest_queue, it};
            end
            restart();
        end
    endtask

    task automatic report(input string what);
        $display("%0t mismatch: %s", $time, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        digests_seen = 0;
        restart();
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
    end

    assign pending_parts = digest_queue.size();

    // monitor both channels
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_word(data_word, byte_count, final_req);
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                    report($sformatf("unexpected digest part %h", digest_part));
                else
                begin
                    want = digest_queue.pop_front();
                    if (digest_part !== want.part)
                        report($sformatf("digest_part %h expected %h", digest_part, want.part));
                    if (digest_last !== want.last)
                        report($sformatf("digest_last %b expected %b", digest_last, want.last));
                    if (want.last)
                        digests_seen++;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: dv/tb_sm3_hash_engine.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_sm3_hash_engine;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        final_req;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_part;
    logic        digest_last;
    int          fail_count;
    int          pending_parts;
    int          digests_seen;
    int          words_sent;

    sm3_hash_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_word(data_word), .byte_count(byte_count), .final_req(final_req),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_part(digest_part), .digest_last(digest_last)
    );

    sm3_digest_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_word(data_word), .byte_count(byte_count), .final_req(final_req),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_part(digest_part), .digest_last(digest_last),
        .fail_count(fail_count), .pending_parts(pending_parts),
        .digests_seen(digests_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // send one item, with a random gap before it (gaps are zero in calm stretches)
    task automatic send_word(input logic [63:0] dw, input logic [3:0] cnt, input logic fin,
                             input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= dw;
        byte_count <= cnt;
        final_req  <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random message: mostly full words, some short ones and empty non-final noise
    task automatic send_message(input int nwords, input bit calm);
        int c;
        for (int i = 0; i < nwords; i++)
        begin
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 8;
            send_word(rand64(), c[3:0], 1'b0, calm);
        end
        send_word(rand64(), 4'($urandom_range(0, 15)), 1'b1, calm);
    endtask

    // receiver wait drawn per item, zero during calm stretches
    bit calm_rx;
    int rx_wait;
    int rx_draw;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            rx_draw = calm_rx ? 0 : $urandom_range(0, 11);
            rx_wait <= rx_draw;
            out_ready <= (rx_draw == 0);
        end
        else if (!out_ready)
        begin
            if (rx_wait > 1)
                rx_wait <= rx_wait - 1;
            else
            begin
                rx_wait <= 0;
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_word = '0;
        byte_count = '0;
        final_req = 1'b0;
        calm_rx = 1'b0;
        words_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, "abc", field extremes, padding boundaries
        send_word('0, 4'd0, 1'b1, 1'b0);
        send_word(64'h6162630000000000, 4'd3, 1'b1, 1'b0);
        send_word('1, 4'd15, 1'b0, 1'b0);
        send_word('0, 4'd0, 1'b0, 1'b0);
        send_word('1, 4'd8, 1'b1, 1'b0);
        for (int i = 0; i < 7; i++)
            send_word(rand64(), 4'd8, 1'b0, 1'b0);
        send_word(rand64(), 4'd0, 1'b1, 1'b0);
        for (int i = 0; i < 7; i++)
            send_word(rand64(), 4'd8, 1'b0, 1'b0);
        send_word(rand64(), 4'd7, 1'b1, 1'b0);

        // random messages, with a calm stretch in the middle
        while (words_sent < 100)
        begin
            calm_rx = (words_sent > 60 && words_sent < 80);
            send_message($urandom_range(0, 18), calm_rx);
        end
        in_valid <= 1'b0;
        calm_rx = 1'b0;

        while (pending_parts != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d words sent, %0d digests checked, empty and multi-block messages included",
                 words_sent, digests_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
